// ----- src/ptom_pkg.sv -----
// Package with the command and status types shared by the order matcher modules.
package ptom_pkg;

  typedef struct packed {
    logic accept;
    logic scan_clear;
    logic scan_en;
    logic remove;
    logic publish;
  } ptom_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic match;
    logic out_full;
  } ptom_sts_t;

endpackage

// ----- src/ptom_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
module ptom_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- src/ptom_ctrl.sv -----
// Controller state machine sequencing insert, best-entry scans, matches and output.
module ptom_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ptom_pkg::ptom_sts_t sts_i,
  output ptom_pkg::ptom_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDone
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept     = 1'b1;
          cmd_o.scan_clear = 1'b1;
          state_d          = StScan;
        end
      end
      StScan: begin
        cmd_o.scan_en = 1'b1;
        if (sts_i.scan_done) begin
          if (sts_i.match) begin
            cmd_o.remove     = 1'b1;
            cmd_o.scan_clear = 1'b1;
          end else begin
            state_d = StDone;
          end
        end
      end
      StDone: begin
        if (!sts_i.out_full) begin
          cmd_o.publish = 1'b1;
          state_d       = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- src/ptom_dpath.sv -----
// Datapath with the two order books, the best-entry scan and the result register.
module ptom_dpath #(
  parameter int BOOK_DEPTH   = 64,
  parameter int PRICE_BITS   = 16,
  parameter int ARRIVAL_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ptom_pkg::ptom_cmd_t cmd_i,
  output ptom_pkg::ptom_sts_t sts_o,
  input  logic                in_func_i,
  input  logic [15:0]         in_price_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [63:0]         out_data_o
);

  localparam int AW = $clog2(BOOK_DEPTH);
  localparam int SW = $clog2(BOOK_DEPTH + 1);
  localparam int EW = PRICE_BITS + ARRIVAL_BITS;

  logic [BOOK_DEPTH-1:0]   bid_vm_q, ask_vm_q;
  logic [SW-1:0]           bid_cnt_q, ask_cnt_q;
  logic [ARRIVAL_BITS-1:0] arrival_q, stamp;
  logic [31:0]             total_q;
  logic                    acc_q, traded_q;
  logic [PRICE_BITS-1:0]   last_q, in_price;
  logic [AW-1:0]           bid_free, ask_free, slot;
  logic                    has_free, bid_we, ask_we;
  logic [EW-1:0]           bid_rd, ask_rd;
  logic [SW-1:0]           scan_q;
  logic                    pend_q;
  logic [AW-1:0]           pidx_q, raddr;
  logic                    bh_q, ah_q;
  logic [PRICE_BITS-1:0]   bp_q, ap_q, rbp, rap;
  logic [ARRIVAL_BITS-1:0] bs_q, as_q, rbs, ras;
  logic [AW-1:0]           bi_q, ai_q;
  logic                    bid_better, ask_better;
  logic [15:0]             last16;
  logic [6:0]              bid7, ask7;
  logic [63:0]             out_q;
  logic                    out_valid_q;

  always_comb begin
    in_price = '0;
    last16   = '0;
    bid7     = '0;
    ask7     = '0;
    for (int k = 0; k < PRICE_BITS; k++) begin
      if (k < 16) in_price[k] = in_price_i[k];
    end
    for (int k = 0; k < 16; k++) begin
      if (k < PRICE_BITS) last16[k] = last_q[k];
    end
    for (int k = 0; k < 7; k++) begin
      if (k < SW) begin
        bid7[k] = bid_cnt_q[k];
        ask7[k] = ask_cnt_q[k];
      end
    end
  end

  always_comb begin
    bid_free = '0;
    ask_free = '0;
    for (int i = BOOK_DEPTH - 1; i >= 0; i--) begin
      if (!bid_vm_q[i]) bid_free = AW'(i);
      if (!ask_vm_q[i]) ask_free = AW'(i);
    end
  end

  assign stamp    = arrival_q + 1'b1;
  assign slot     = in_func_i ? ask_free : bid_free;
  assign has_free = in_func_i ? ~&ask_vm_q : ~&bid_vm_q;
  assign bid_we   = cmd_i.accept && !in_func_i && has_free;
  assign ask_we   = cmd_i.accept && in_func_i && has_free;
  assign raddr    = scan_q[AW-1:0];

  ptom_ram #(.WIDTH(EW), .DEPTH(BOOK_DEPTH)) u_bid_ram (
    .clk_i  (clk_i),
    .we_i   (bid_we),
    .waddr_i(slot),
    .wdata_i({in_price, stamp}),
    .raddr_i(raddr),
    .rdata_o(bid_rd)
  );

  ptom_ram #(.WIDTH(EW), .DEPTH(BOOK_DEPTH)) u_ask_ram (
    .clk_i  (clk_i),
    .we_i   (ask_we),
    .waddr_i(slot),
    .wdata_i({in_price, stamp}),
    .raddr_i(raddr),
    .rdata_o(ask_rd)
  );

  assign rbp = bid_rd[EW-1:ARRIVAL_BITS];
  assign rbs = bid_rd[ARRIVAL_BITS-1:0];
  assign rap = ask_rd[EW-1:ARRIVAL_BITS];
  assign ras = ask_rd[ARRIVAL_BITS-1:0];

  assign bid_better = bid_vm_q[pidx_q] &&
                      (!bh_q || ((rbp != bp_q) ? (rbp > bp_q) : (rbs < bs_q)));
  assign ask_better = ask_vm_q[pidx_q] &&
                      (!ah_q || ((rap != ap_q) ? (rap < ap_q) : (ras < as_q)));

  assign sts_o.scan_done = (scan_q == SW'(BOOK_DEPTH)) && !pend_q;
  assign sts_o.match     = bh_q && ah_q && (bp_q == ap_q);
  assign sts_o.out_full  = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bid_vm_q    <= '0;
      ask_vm_q    <= '0;
      bid_cnt_q   <= '0;
      ask_cnt_q   <= '0;
      arrival_q   <= '0;
      total_q     <= '0;
      scan_q      <= '0;
      pend_q      <= 1'b0;
      bh_q        <= 1'b0;
      ah_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        arrival_q <= stamp;
        if (bid_we) begin
          bid_vm_q[slot] <= 1'b1;
          bid_cnt_q      <= bid_cnt_q + 1'b1;
        end
        if (ask_we) begin
          ask_vm_q[slot] <= 1'b1;
          ask_cnt_q      <= ask_cnt_q + 1'b1;
        end
      end
      if (cmd_i.remove) begin
        bid_vm_q[bi_q] <= 1'b0;
        ask_vm_q[ai_q] <= 1'b0;
        bid_cnt_q      <= bid_cnt_q - 1'b1;
        ask_cnt_q      <= ask_cnt_q - 1'b1;
        total_q        <= total_q + 1'b1;
      end
      if (cmd_i.scan_clear) begin
        scan_q <= '0;
        pend_q <= 1'b0;
        bh_q   <= 1'b0;
        ah_q   <= 1'b0;
      end else if (cmd_i.scan_en) begin
        if (scan_q < SW'(BOOK_DEPTH)) begin
          scan_q <= scan_q + 1'b1;
          pend_q <= 1'b1;
        end else begin
          pend_q <= 1'b0;
        end
        if (pend_q && bid_better) bh_q <= 1'b1;
        if (pend_q && ask_better) ah_q <= 1'b1;
      end
      if (cmd_i.publish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q <= raddr;
    if (cmd_i.accept) begin
      acc_q    <= has_free;
      traded_q <= 1'b0;
      last_q   <= '0;
    end
    if (cmd_i.remove) begin
      traded_q <= 1'b1;
      last_q   <= bp_q;
    end
    if (cmd_i.scan_en && pend_q) begin
      if (bid_better) begin
        bp_q <= rbp;
        bs_q <= rbs;
        bi_q <= pidx_q;
      end
      if (ask_better) begin
        ap_q <= rap;
        as_q <= ras;
        ai_q <= pidx_q;
      end
    end
    if (cmd_i.publish) begin
      out_q <= {ask7, bid7, total_q, last16, traded_q, acc_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- src/price_time_order_matcher_top.sv -----
// Top level of the price-time priority order matcher.
// Orders arrive on the slave stream: tuser carries the side (0 buy, 1 sell)
// and tdata the limit price. Each order gives exactly one result item on the
// master stream with the accepted and traded flags, the trade price, the
// running trade count and the resting bid and ask counts.
// One order is worked on at a time. The order is written into the first free
// slot of its side in the accept cycle, then both books are scanned for their
// best entries through the RAM read port, one slot per cycle. Each trade found
// removes the two best orders and starts another scan.
// The result waits in an output register; while the receiver stalls the
// matcher finishes its work and holds before taking the next order.
// Reset empties both books and clears the arrival and trade counters; the
// price and stamp RAMs keep stale data that the valid marks hide.
module price_time_order_matcher_top #(
  parameter int BOOK_DEPTH   = 64,
  parameter int PRICE_BITS   = 16,
  parameter int ARRIVAL_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // price
  input  logic        s_axis_tuser,  // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata   // accepted, traded, trade_price, trade_total,
                                     // bid_count, ask_count
);

  ptom_pkg::ptom_cmd_t cmd;
  ptom_pkg::ptom_sts_t sts;

  ptom_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  ptom_dpath #(
    .BOOK_DEPTH  (BOOK_DEPTH),
    .PRICE_BITS  (PRICE_BITS),
    .ARRIVAL_BITS(ARRIVAL_BITS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_func_i  (s_axis_tuser),
    .in_price_i (s_axis_tdata),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("matcher took a new order while busy");

  a_no_trade_no_price: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[1]) |-> (m_axis_tdata[17:2] == 16'd0))
    else $error("trade price set without a trade");

  a_remove_only_on_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.remove |-> (sts.match && sts.scan_done))
    else $error("orders removed without a matching pair");

endmodule

// ----- tb/ptom_checker.sv -----
// Checker that predicts the order matcher results and compares them with the output stream.
`timescale 1ns / 1ps
module ptom_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int DEPTH = 64;

  typedef struct packed {
    logic        accepted;
    logic        traded;
    logic [15:0] trade_price;
    logic [31:0] trade_total;
    logic [6:0]  bid_count;
    logic [6:0]  ask_count;
  } book_result_t;

  logic [15:0] bid_px[DEPTH];
  logic [31:0] bid_stamp[DEPTH];
  logic        bid_live[DEPTH];
  logic [15:0] ask_px[DEPTH];
  logic [31:0] ask_stamp[DEPTH];
  logic        ask_live[DEPTH];
  logic [31:0] stamp_now;
  logic [31:0] trades_now;
  book_result_t expected_results[$];
  int fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_results.size();

  task automatic report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  function automatic int best_slot(input bit is_bid);
    int b;
    logic [15:0] p;
    logic [31:0] s;
    b = -1;
    for (int i = 0; i < DEPTH; i++) begin
      if (is_bid ? bid_live[i] : ask_live[i]) begin
        p = is_bid ? bid_px[i] : ask_px[i];
        s = is_bid ? bid_stamp[i] : ask_stamp[i];
        if (b < 0) b = i;
        else if (p != (is_bid ? bid_px[b] : ask_px[b])) begin
          if (is_bid ? (p > bid_px[b]) : (p < ask_px[b])) b = i;
        end else if (s < (is_bid ? bid_stamp[b] : ask_stamp[b])) b = i;
      end
    end
    return b;
  endfunction

  task automatic match_order(input logic sell, input logic [15:0] price);
    book_result_t r;
    int b, a, nb, na;
    bit done;
    r = '0;
    stamp_now = stamp_now + 1;
    for (int i = 0; i < DEPTH && !r.accepted; i++) begin
      if (sell && !ask_live[i]) begin
        ask_px[i] = price; ask_stamp[i] = stamp_now; ask_live[i] = 1'b1; r.accepted = 1'b1;
      end else if (!sell && !bid_live[i]) begin
        bid_px[i] = price; bid_stamp[i] = stamp_now; bid_live[i] = 1'b1; r.accepted = 1'b1;
      end
    end
    done = 0;
    for (int k = 0; k < DEPTH && !done; k++) begin
      b = best_slot(1'b1);
      a = best_slot(1'b0);
      if (b < 0 || a < 0) done = 1;
      else if (bid_px[b] != ask_px[a]) done = 1;
      else begin
        r.traded = 1'b1;
        r.trade_price = bid_px[b];
        bid_live[b] = 1'b0;
        ask_live[a] = 1'b0;
        trades_now = trades_now + 1;
      end
    end
    nb = 0; na = 0;
    for (int i = 0; i < DEPTH; i++) begin
      nb += bid_live[i];
      na += ask_live[i];
    end
    r.trade_total = trades_now;
    r.bid_count = nb[6:0];
    r.ask_count = na[6:0];
    expected_results = {expected_results, r};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    book_result_t got, want;
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        bid_live[i] = 1'b0;
        ask_live[i] = 1'b0;
      end
      stamp_now  = '0;
      trades_now = '0;
      fails      = 0;
      expected_results.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '0;
        got.accepted    = m_axis_tdata[0];
        got.traded      = m_axis_tdata[1];
        got.trade_price = m_axis_tdata[17:2];
        got.trade_total = m_axis_tdata[49:18];
        got.bid_count   = m_axis_tdata[56:50];
        got.ask_count   = m_axis_tdata[63:57];
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata, '0);
        end else begin
          want = expected_results.pop_front();
          if (got.accepted != want.accepted)
            report_mismatch("accepted", 64'(got.accepted), 64'(want.accepted));
          if (got.traded != want.traded)
            report_mismatch("traded", 64'(got.traded), 64'(want.traded));
          if (got.trade_price != want.trade_price)
            report_mismatch("trade_price", 64'(got.trade_price), 64'(want.trade_price));
          if (got.trade_total != want.trade_total)
            report_mismatch("trade_total", 64'(got.trade_total), 64'(want.trade_total));
          if (got.bid_count != want.bid_count)
            report_mismatch("bid_count", 64'(got.bid_count), 64'(want.bid_count));
          if (got.ask_count != want.ask_count)
            report_mismatch("ask_count", 64'(got.ask_count), 64'(want.ask_count));
        end
      end
      if (s_axis_tvalid && s_axis_tready) match_order(s_axis_tuser, s_axis_tdata);
    end
  end

endmodule

// ----- tb/testbench.sv -----
// Testbench top that drives orders into the matcher and gives the verdict.
`timescale 1ns / 1ps
module testbench;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  int          fail_count;
  int          pending;
  int          send_idle_pct;
  int          recv_stall_pct;

  price_time_order_matcher_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  ptom_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_order(input logic sell, input logic [15:0] price);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= sell;
    s_axis_tdata  <= price;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_phase(input int n);
    case (n % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
      default: begin send_idle_pct = 32; recv_stall_pct = 32; end
    endcase
  endtask

  initial begin
    logic [15:0] base;
    int kind;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    m_axis_tready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // Extremes, a crossed book and equal-price orders queued on both sides.
    send_order(1'b0, 16'h0000);
    send_order(1'b1, 16'h0000);
    send_order(1'b1, 16'hFFFF);
    send_order(1'b0, 16'hFFFF);
    send_order(1'b0, 16'h8000);
    send_order(1'b1, 16'h7000);
    send_order(1'b0, 16'h5555);
    send_order(1'b0, 16'h5555);
    send_order(1'b1, 16'h5555);
    send_order(1'b1, 16'h5555);
    send_order(1'b1, 16'hAAAA);
    send_order(1'b0, 16'hAAAA);
    // Fill the bid side past its depth so that orders are rejected, then do the same on the ask side.
    for (int i = 0; i < 70; i++) send_order(1'b0, 16'd100);
    for (int i = 0; i < 70; i++) send_order(1'b1, 16'd100);
    for (int p = 0; p < 8; p++) begin
      set_phase(p);
      base = 16'($urandom);
      for (int i = 0; i < 120; i++) begin
        kind = $urandom_range(9);
        if (kind < 7) begin
          send_order(1'($urandom_range(1)), base + 16'($urandom_range(7)));
        end else begin
          send_order(1'($urandom_range(1)), 16'($urandom));
        end
      end
    end
    s_axis_tvalid <= 1'b0;
    set_phase(0);
    fork
      begin
        while (pending != 0) @(posedge clk_i);
        repeat (200) @(posedge clk_i);
      end
    join
    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("testbench: errors");
    $finish;
  end

endmodule
